@@ rtl/core/assert_macros.svh @@
// Assertion macros for the Huffman code builder datapath.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HCB_ASSERT(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define HCB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HCB_ASSERT(name, expr)
`define HCB_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ rtl/core/hcb_pkg.sv @@
// Package for the Huffman code builder: request types, defaults and the
// command/status bundles between controller and datapath. No dependencies.
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF  = 32;
    localparam int WEIGHT_WIDTH_DEF = 16;
    localparam int RESULT_CAP       = 32;
    localparam int IN_WEIGHT_W      = 16;
    localparam int SYM_W            = 5;
    localparam int CODE_W           = 31;
    localparam int LEN_W            = 5;

    typedef struct packed {
        logic [IN_WEIGHT_W-1:0] weight;
        logic                   last_symbol;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol_index;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic              last_code;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_leaf;
        logic build_init;
        logic scan_issue;
        logic mark_a;
        logic mark_b;
        logic write_b;
        logic walk_init;
        logic walk_read;
        logic walk_step;
        logic emit;
        logic leaf_next;
        logic clear_count;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic merges_done;
        logic scan_last;
        logic walk_top;
        logic leaf_last;
        logic out_free;
    } status_t;

endpackage

@@ rtl/core/huffman_code_builder.sv @@
// Huffman code builder top level: controller plus node-table datapath.
// Depends on hcb_pkg, hcb_ctrl and hcb_datapath.
//
// Usage: send symbol weights on the input channel (in_valid/in_ready), one
// request per symbol in symbol order; set last_symbol on the final one.
// Weights past MAX_SYMBOLS are dropped. The last request starts the build;
// in_ready stays low until the last code is loaded into the output register.
// Build: each of the n-1 merge rounds for node i scans nodes 0..i-1 twice
// through the single read port of the weight memory, then writes the
// merged weight and the two parent links.
// Code walk: per leaf, a parent memory read and then a step for each tree
// level, then the code is loaded into the output register.
// Results leave on out_valid/out_ready in symbol order, one per leaf (at
// most 32), last_code set on the final one. If the receiver stalls, the
// walk waits at the output register; nothing is dropped.
// Reset clears the leaf count and all control state; the node table needs
// no clearing, every entry is written before use.
module huffman_code_builder #(
    parameter int MAX_SYMBOLS  = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int WEIGHT_WIDTH = hcb_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hcb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hcb_pkg::out_item_t out_data
);
    import hcb_pkg::*;

    cmd_t    cmd;
    status_t status;

    hcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last_symbol),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hcb_datapath #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ rtl/core/hcb_ctrl.sv @@
// Sequencer for the Huffman code builder: load, merge rounds, code walk, emit.
// Depends on hcb_pkg.
module hcb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_ready,
    input  hcb_pkg::status_t status,
    output hcb_pkg::cmd_t    cmd
);
    import hcb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_MERGE, S_SCAN_A, S_DRAIN_A, S_MARK_A,
        S_SCAN_B, S_DRAIN_B, S_MARK_B, S_WRITE_B,
        S_WALK_INIT, S_WALK_CHECK, S_WALK_WAIT, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic accept;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_leaf = 1'b1;
                    if (in_last)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.build_init = 1'b1;
                state_next     = S_MERGE;
            end
            S_MERGE:
                state_next = status.merges_done ? S_WALK_INIT : S_SCAN_A;
            S_SCAN_A:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                    state_next = S_DRAIN_A;
            end
            S_DRAIN_A:
                state_next = S_MARK_A;
            S_MARK_A:
            begin
                cmd.mark_a = 1'b1;
                state_next = S_SCAN_B;
            end
            S_SCAN_B:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                    state_next = S_DRAIN_B;
            end
            S_DRAIN_B:
                state_next = S_MARK_B;
            S_MARK_B:
            begin
                cmd.mark_b = 1'b1;
                state_next = S_WRITE_B;
            end
            S_WRITE_B:
            begin
                cmd.write_b = 1'b1;
                state_next  = S_MERGE;
            end
            S_WALK_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_WALK_CHECK;
            end
            S_WALK_CHECK:
            begin
                if (status.walk_top)
                    state_next = S_EMIT;
                else
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT:
            begin
                cmd.walk_step = 1'b1;
                state_next    = S_WALK_CHECK;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.leaf_last)
                    begin
                        cmd.clear_count = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.leaf_next = 1'b1;
                        state_next    = S_WALK_INIT;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/hcb_datapath.sv @@
// Node table, min-weight scan, parent walk and output register of the
// Huffman code builder. Depends on hcb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hcb_datapath #(
    parameter int MAX_SYMBOLS  = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int WEIGHT_WIDTH = hcb_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hcb_pkg::in_item_t in_data,
    input  hcb_pkg::cmd_t     cmd,
    output hcb_pkg::status_t  status,
    input  logic              out_ready,
    output logic              out_valid,
    output hcb_pkg::out_item_t out_data
);
    import hcb_pkg::*;

    localparam int NODES = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W = $clog2(2 * MAX_SYMBOLS);
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int NW    = WEIGHT_WIDTH + IDX_W;
    localparam int WIN_W = (WEIGHT_WIDTH < IN_WEIGHT_W) ? WEIGHT_WIDTH : IN_WEIGHT_W;

    // Node table memories
    logic [NW-1:0]    weight_mem [NODES];
    logic [IDX_W-1:0] parent_mem [NODES];

    // Per-node flags
    logic [NODES-1:0] hp_reg;
    logic [NODES-1:0] right_reg;

    logic [CNT_W-1:0] leaf_count_reg;
    logic [IDX_W-1:0] node_i_reg;
    logic [IDX_W-1:0] scan_j_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [NW-1:0]    weight_rd_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [NW-1:0]    best_w_reg;
    logic [IDX_W-1:0] a_reg;
    logic [NW-1:0]    wa_reg;
    logic [IDX_W-1:0] b_reg;
    logic [IDX_W-1:0] leaf_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] len_reg;
    logic [CODE_W-1:0] code_reg;
    logic [IDX_W-1:0] parent_rd_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic [NW-1:0]    w_in;
    logic             cand;
    logic [IDX_W:0]   total;
    logic [IDX_W:0]   emit_lim;
    logic             room;

    assign w_in = NW'(in_data.weight[WIN_W-1:0]);
    assign room = (leaf_count_reg < CNT_W'(MAX_SYMBOLS));

    // Candidate for least unparented weight
    assign cand = rd_valid_reg && !hp_reg[rd_idx_reg] &&
                  (!found_reg || (weight_rd_reg < best_w_reg));

    // Status
    assign total    = ((IDX_W+1)'(leaf_count_reg) << 1) - (IDX_W+1)'(1);
    assign emit_lim = ((IDX_W+1)'(leaf_count_reg) > (IDX_W+1)'(RESULT_CAP))
                      ? (IDX_W+1)'(RESULT_CAP) : (IDX_W+1)'(leaf_count_reg);
    assign status.merges_done = ({1'b0, node_i_reg} == total);
    assign status.scan_last   = (scan_j_reg == node_i_reg - IDX_W'(1));
    assign status.walk_top    = !hp_reg[cur_reg];
    assign status.leaf_last   = ({1'b0, leaf_reg} == emit_lim - (IDX_W+1)'(1));
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_leaf && room)
            weight_mem[IDX_W'(leaf_count_reg)] <= w_in;
        else if (cmd.mark_b)
            weight_mem[node_i_reg] <= wa_reg + best_w_reg;
        if (cmd.mark_b)
            parent_mem[a_reg] <= node_i_reg;
        else if (cmd.write_b)
            parent_mem[b_reg] <= node_i_reg;
        weight_rd_reg <= weight_mem[scan_j_reg];
        if (cmd.walk_read)
            parent_rd_reg <= parent_mem[cur_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_j_reg;
        if (cand)
        begin
            best_idx_reg <= rd_idx_reg;
            best_w_reg   <= weight_rd_reg;
        end
        if (cmd.mark_a)
        begin
            a_reg  <= best_idx_reg;
            wa_reg <= best_w_reg;
        end
        if (cmd.mark_b)
            b_reg <= best_idx_reg;
        if (cmd.walk_init)
        begin
            cur_reg  <= leaf_reg;
            len_reg  <= '0;
            code_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            cur_reg <= parent_rd_reg;
            len_reg <= len_reg + IDX_W'(1);
            if (right_reg[cur_reg])
                code_reg <= code_reg | (CODE_W'(1) << len_reg);
        end
        if (cmd.emit)
        begin
            out_reg.symbol_index <= SYM_W'(leaf_reg);
            out_reg.code_bits    <= code_reg;
            out_reg.code_length  <= LEN_W'(len_reg);
            out_reg.last_code    <= status.leaf_last;
        end
    end

    // Control registers and node flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= '0;
            node_i_reg     <= '0;
            scan_j_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            leaf_reg       <= '0;
            out_valid_reg  <= 1'b0;
            hp_reg         <= '0;
            right_reg      <= '0;
        end
        else
        begin
            if (cmd.load_leaf && room)
            begin
                leaf_count_reg <= leaf_count_reg + CNT_W'(1);
                hp_reg[IDX_W'(leaf_count_reg)] <= 1'b0;
            end
            else if (cmd.clear_count)
                leaf_count_reg <= '0;

            // Internal nodes start unparented
            if (cmd.build_init)
            begin
                node_i_reg <= IDX_W'(leaf_count_reg);
                leaf_reg   <= '0;
                for (int k = 0; k < NODES; k++)
                begin
                    if (k >= int'(leaf_count_reg))
                        hp_reg[k] <= 1'b0;
                end
            end

            // Scan address and read pipeline
            scan_j_reg   <= cmd.scan_issue ? scan_j_reg + IDX_W'(1) : '0;
            rd_valid_reg <= cmd.scan_issue;
            if (cand)
                found_reg <= 1'b1;
            else if (cmd.scan_issue && scan_j_reg == '0)
                found_reg <= 1'b0;

            if (cmd.mark_a)
            begin
                hp_reg[best_idx_reg]    <= 1'b1;
                right_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.mark_b)
            begin
                hp_reg[best_idx_reg] <= 1'b1;
                hp_reg[node_i_reg]   <= 1'b0;
            end
            if (cmd.write_b)
            begin
                right_reg[b_reg] <= 1'b1;
                node_i_reg       <= node_i_reg + IDX_W'(1);
            end

            if (cmd.leaf_next)
                leaf_reg <= leaf_reg + IDX_W'(1);

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // A merge pick is a live node: the first is unparented, the second is not the first
    `HCB_ASSERT(a_pick_free, !cmd.mark_a || (found_reg && !hp_reg[best_idx_reg]))
    `HCB_ASSERT(b_pick_free, !cmd.mark_b || (found_reg && best_idx_reg != a_reg))
    // A result is only loaded into a free output slot
    `HCB_ASSERT(emit_slot_free, !cmd.emit || !out_valid_reg || out_ready)
    `HCB_ASSERT_NEXT(emit_shows, cmd.emit, out_valid_reg)

endmodule
